@@ rtl/fca_pkg.sv @@
// ----------------------------------------------------------------------------
// fca_pkg: shared types and constants
// Field widths, command and status codes, and the command and status
// groups passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fca_pkg;

   localparam int CMD_W     = 1;
   localparam int LEN_W     = 11;
   localparam int HEAD_W    = 10;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_SHORT = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic clear;
      logic accept;
      logic scan;
      logic link_end;
      logic walk;
      logic reply;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic req_alloc;
      logic alloc_skip;
      logic free_skip;
      logic scan_done;
      logic walk_done;
      logic rsp_busy;
   } dp_stat_type;

endpackage

`default_nettype wire

@@ rtl/fca_req_if.sv @@
// ----------------------------------------------------------------------------
// fca_req_if: command channel
// Valid/ready channel carrying one allocate or free command per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface fca_req_if;
   import fca_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [LEN_W-1:0]  chain_length;
   logic [HEAD_W-1:0] chain_head;

   modport source (output valid, command, chain_length, chain_head, input ready);
   modport sink   (input valid, command, chain_length, chain_head, output ready);
endinterface

`default_nettype wire

@@ rtl/fca_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fca_rsp_if: result channel
// Valid/ready channel carrying one result per command.
// ----------------------------------------------------------------------------
`default_nettype none

interface fca_rsp_if;
   import fca_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [HEAD_W-1:0]    head_index;
   logic [CNT_OUT_W-1:0] freed_count;
   logic [CNT_OUT_W-1:0] free_remaining;

   modport source (output valid, status, head_index, freed_count, free_remaining,
                   input ready);
   modport sink   (input valid, status, head_index, freed_count, free_remaining,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/fat_chain_allocator.sv @@
// ----------------------------------------------------------------------------
// fat_chain_allocator: file-allocation table chain allocator
// Allocates chains of free table entries in ascending order and frees
// chains by walking their links.
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    command, chain_length, chain_head
//   rsp_if   out  valid/ready    status, head_index, freed_count, free_remaining
//
// After reset the table is swept to free, one entry a cycle, with req_if.ready
// low until the sweep ends.
// Allocate: accept, scan reading one table entry a cycle through the single
// memory read port, link the chain end, reply; refused or zero length: reply.
// Free: accept, walk (one link followed a cycle), reply; head out of range: reply.
// One command at a time; the next is taken while the result waits in the
// output register. A stalled result holds the reply step.
// ----------------------------------------------------------------------------
`default_nettype none

module fat_chain_allocator #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic      clock,
   input  logic      reset,
   fca_req_if.sink   req_if,
   fca_rsp_if.source rsp_if
);
   import fca_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   fca_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   fca_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (dp_cmd),
      .stat               (dp_stat),
      .req_command        (req_if.command),
      .req_chain_length   (req_if.chain_length),
      .req_chain_head     (req_if.chain_head),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_status         (rsp_if.status),
      .rsp_head_index     (rsp_if.head_index),
      .rsp_freed_count    (rsp_if.freed_count),
      .rsp_free_remaining (rsp_if.free_remaining)
   );

endmodule

`default_nettype wire

@@ rtl/fca_datapath.sv @@
// ----------------------------------------------------------------------------
// fca_datapath: link table, counters and result register
// Holds the link table memory (one write, one registered read per cycle),
// the free count, the scan and walk registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_datapath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fca_pkg::dp_cmd_type           cmd,
   output fca_pkg::dp_stat_type          stat,
   input  logic [fca_pkg::CMD_W-1:0]     req_command,
   input  logic [fca_pkg::LEN_W-1:0]     req_chain_length,
   input  logic [fca_pkg::HEAD_W-1:0]    req_chain_head,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fca_pkg::STAT_W-1:0]    rsp_status,
   output logic [fca_pkg::HEAD_W-1:0]    rsp_head_index,
   output logic [fca_pkg::CNT_OUT_W-1:0] rsp_freed_count,
   output logic [fca_pkg::CNT_OUT_W-1:0] rsp_free_remaining
);
   import fca_pkg::*;

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = IDX_W + 1;
   localparam int LCMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int HCMP_W  = (CNT_W > HEAD_W) ? CNT_W : HEAD_W;

   localparam logic [ENTRY_W-1:0] MARK_FREE = '1;
   localparam logic [ENTRY_W-1:0] MARK_END  = {1'b1, {IDX_W{1'b0}}};
   localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0]   DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

   logic [ENTRY_W-1:0]   rd_data_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]   wr_data;

   logic [IDX_W-1:0]     clr_ff, clr_in;
   logic [CNT_W-1:0]     free_total_ff, free_total_in;
   logic [LEN_W-1:0]     length_ff, length_in;
   logic [STAT_W-1:0]    status_ff, status_in;
   logic [IDX_W-1:0]     head_out_ff, head_out_in;
   logic [IDX_W-1:0]     prev_ff, prev_in;
   logic [CNT_W-1:0]     made_ff, made_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [HEAD_W-1:0]    rsp_head_ff, rsp_head_in;
   logic [CNT_OUT_W-1:0] rsp_freed_ff, rsp_freed_in;
   logic [CNT_OUT_W-1:0] rsp_remain_ff, rsp_remain_in;

   logic                 entry_free;
   logic                 entry_end;
   logic [CNT_W-1:0]     made_next;
   logic [CNT_W-1:0]     count_next;
   logic                 len_short;
   logic                 head_bad;

   assign entry_free = (rd_data_ff == MARK_FREE);
   assign entry_end  = (rd_data_ff == MARK_END);
   assign made_next  = made_ff + 1'b1;
   assign count_next = count_ff + 1'b1;
   assign len_short  = LCMP_W'(req_chain_length) > LCMP_W'(free_total_ff);
   assign head_bad   = HCMP_W'(req_chain_head) >= HCMP_W'(TABLE_DEPTH);

   always_comb begin
      stat.clear_done = (clr_ff == LAST_IDX);
      stat.req_alloc  = (req_command == CMD_ALLOC);
      stat.alloc_skip = (req_chain_length == '0) || len_short;
      stat.free_skip  = head_bad;
      stat.scan_done  = (entry_free && (LCMP_W'(made_next) == LCMP_W'(length_ff)))
                        || (rd_idx_ff == LAST_IDX);
      stat.walk_done  = entry_free || entry_end || (count_next == DEPTH_CNT);
      stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // read address
   always_comb begin
      priority if (cmd.accept) begin
         rd_addr = (req_command == CMD_ALLOC) ? '0 : IDX_W'(req_chain_head);
      end else if (cmd.scan) begin
         rd_addr = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
      end else if (cmd.walk) begin
         rd_addr = rd_data_ff[IDX_W-1:0];
      end else begin
         rd_addr = rd_idx_ff;
      end
   end

   // write port
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = MARK_FREE;
      priority if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (cmd.scan && entry_free && (made_ff != '0)) begin
         wr_en   = 1'b1;
         wr_addr = prev_ff;
         wr_data = {1'b0, rd_idx_ff};
      end else if (cmd.link_end && (made_ff != '0)) begin
         wr_en   = 1'b1;
         wr_addr = prev_ff;
         wr_data = MARK_END;
      end else if (cmd.walk && !entry_free) begin
         wr_en   = 1'b1;
      end else begin
         wr_en   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
      rd_idx_ff  <= rd_addr;
   end

   always_comb begin
      clr_in        = cmd.clear ? clr_ff + 1'b1 : clr_ff;
      free_total_in = free_total_ff;
      length_in     = length_ff;
      status_in     = status_ff;
      head_out_in   = head_out_ff;
      prev_in       = prev_ff;
      made_in       = made_ff;
      count_in      = count_ff;

      if (cmd.accept) begin
         length_in   = req_chain_length;
         head_out_in = '0;
         made_in     = '0;
         count_in    = '0;
         if (req_command == CMD_ALLOC) begin
            status_in = len_short ? ST_SHORT : ST_DONE;
         end else begin
            status_in = head_bad ? ST_RANGE : ST_DONE;
         end
      end

      if (cmd.scan && entry_free) begin
         made_in       = made_next;
         prev_in       = rd_idx_ff;
         free_total_in = free_total_ff - 1'b1;
         if (made_ff == '0) begin
            head_out_in = rd_idx_ff;
         end
      end

      if (cmd.walk && !entry_free) begin
         count_in = count_next;
         if (free_total_ff != DEPTH_CNT) begin
            free_total_in = free_total_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_head_in   = rsp_head_ff;
      rsp_freed_in  = rsp_freed_ff;
      rsp_remain_in = rsp_remain_ff;
      if (cmd.reply) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_head_in   = HEAD_W'(head_out_ff);
         rsp_freed_in  = CNT_OUT_W'(count_ff);
         rsp_remain_in = CNT_OUT_W'(free_total_ff);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         free_total_ff <= DEPTH_CNT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_ff        <= clr_in;
         free_total_ff <= free_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      length_ff     <= length_in;
      status_ff     <= status_in;
      head_out_ff   <= head_out_in;
      prev_ff       <= prev_in;
      made_ff       <= made_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_freed_ff  <= rsp_freed_in;
      rsp_remain_ff <= rsp_remain_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_head_index     = rsp_head_ff;
   assign rsp_freed_count    = rsp_freed_ff;
   assign rsp_free_remaining = rsp_remain_ff;

endmodule

`default_nettype wire

@@ rtl/fca_controller.sv @@
// ----------------------------------------------------------------------------
// fca_controller: command sequencer
// Steps the table clear, the allocate scan, the free walk and the reply.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fca_pkg::dp_stat_type stat,
   output fca_pkg::dp_cmd_type  cmd
);
   import fca_pkg::*;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_SCAN  = 6'b000100,
      S_LINK  = 6'b001000,
      S_WALK  = 6'b010000,
      S_REPLY = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.req_alloc) begin
                  state_in = stat.alloc_skip ? S_REPLY : S_SCAN;
               end else begin
                  state_in = stat.free_skip ? S_REPLY : S_WALK;
               end
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               state_in = S_LINK;
            end
         end
         S_LINK: begin
            cmd.link_end = 1'b1;
            state_in     = S_REPLY;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_done) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            if (!stat.rsp_busy) begin
               cmd.reply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fca_checker.sv @@
// ----------------------------------------------------------------------------
// fca_checker: port-level checks
// Watches the command and result channels of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module fca_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fca_pkg::STAT_W-1:0]    rsp_status,
   input logic [fca_pkg::HEAD_W-1:0]    rsp_head_index,
   input logic [fca_pkg::CNT_OUT_W-1:0] rsp_freed_count,
   input logic [fca_pkg::CNT_OUT_W-1:0] rsp_free_remaining
);
   import fca_pkg::*;

   a_reset_blocks_req: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second command taken while one is in progress");

   a_refused_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_DONE)) |->
         ((rsp_head_index == '0) && (rsp_freed_count == '0)))
      else $error("refused command reports a head or a freed count");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_head_index)
          && $stable(rsp_freed_count) && $stable(rsp_free_remaining)))
      else $error("stalled result beat changed");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_head_index     (rsp_if.head_index),
   .rsp_freed_count    (rsp_if.freed_count),
   .rsp_free_remaining (rsp_if.free_remaining)
);

`default_nettype wire
